// ===== rtl/srfr_pkg.sv =====
// Package for the sensor reply frame receiver.
// Status codes, frame constants and the value range check; no dependencies.
package srfr_pkg;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_CHECKSUM = 3'd1,
    ST_VALUE    = 3'd2,
    ST_ADDRESS  = 3'd3,
    ST_COMMAND  = 3'd4
  } status_e;

  typedef enum logic [0:0] {
    REG_START_BYTE = 1'b0,
    REG_DEV_ADDR   = 1'b1
  } reg_idx_e;

  localparam logic [3:0]  FrameLen     = 4'd12;
  localparam logic [7:0]  CmdMeasure   = 8'h01;
  localparam logic [30:0] ExpAllOnes   = 31'h7F80_0000;
  localparam logic [30:0] PosLimitMag  = 31'h453B_8000;
  localparam logic [30:0] NegLimitMag  = 31'h42C8_0000;

  typedef struct packed {
    logic        done;
    logic        addr_ok;
    logic        sum_ok;
    logic        cmd_ok;
    logic [31:0] value;
  } frame_info_t;

  function automatic logic value_invalid(input logic [31:0] bits);
    logic [30:0] mag;
    mag = bits[30:0];
    return (mag >= ExpAllOnes) || (!bits[31] && mag > PosLimitMag) ||
           (bits[31] && mag > NegLimitMag);
  endfunction

endpackage

// ===== rtl/srfr_collect.sv =====
// Frame collector: tracks frame position, running XOR checksum and fields.
// Depends on srfr_pkg.
module srfr_collect (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 beat_i,
  input  logic [7:0]           rx_byte_i,
  input  logic [7:0]           start_byte_i,
  input  logic [7:0]           device_address_i,
  output srfr_pkg::frame_info_t info_o
);
  import srfr_pkg::*;

  logic       in_frame_q, in_frame_d;
  logic [3:0] count_q, count_d;
  logic [7:0] sum_q, sum_d;
  logic       addr_ok_q, addr_ok_d, cmd_ok_q, cmd_ok_d;
  logic [31:0] value_q, value_d;
  logic       last;

  assign last = in_frame_q && (count_q == FrameLen - 4'd1);

  always_comb begin
    in_frame_d = in_frame_q;
    count_d    = count_q;
    sum_d      = sum_q;
    addr_ok_d  = addr_ok_q;
    cmd_ok_d   = cmd_ok_q;
    value_d    = value_q;
    if (beat_i) begin
      if (!in_frame_q) begin
        if (rx_byte_i == start_byte_i) begin
          in_frame_d = 1'b1;
          count_d    = 4'd1;
          sum_d      = rx_byte_i;
        end
      end else if (last) begin
        in_frame_d = 1'b0;
        count_d    = 4'd0;
      end else begin
        count_d = count_q + 4'd1;
        sum_d   = sum_q ^ rx_byte_i;
        if (count_q == 4'd1) addr_ok_d = (rx_byte_i == device_address_i);
        if (count_q == 4'd2) cmd_ok_d = (rx_byte_i == CmdMeasure);
        if (count_q >= 4'd7) value_d = {value_q[23:0], rx_byte_i};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      count_q    <= 4'd0;
    end else begin
      in_frame_q <= in_frame_d;
      count_q    <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q     <= sum_d;
    addr_ok_q <= addr_ok_d;
    cmd_ok_q  <= cmd_ok_d;
    value_q   <= value_d;
  end

  always_comb begin
    info_o.done    = beat_i && last;
    info_o.addr_ok = addr_ok_q;
    info_o.sum_ok  = (sum_q == rx_byte_i);
    info_o.cmd_ok  = cmd_ok_q;
    info_o.value   = value_q;
  end
endmodule

// ===== rtl/sensor_reply_frame_receiver_core.sv =====
// Top level of the sensor reply frame receiver.
// Uses srfr_pkg and srfr_collect; holds config, judge and result register.
//
// One byte beat per cycle is taken while in_stall_o is low. A frame opens on the start byte and
// closes 11 beats later; the closing beat yields one result beat on the
// next cycle from the output register. Input stall follows only output
// stall while a result is held, so frames stream back to back.
module sensor_reply_frame_receiver_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [31:0] value_bits_o,
  output logic [31:0] error_total_o,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i
);
  import srfr_pkg::*;

  logic [7:0]  start_q, addr_q;
  logic        beat;
  frame_info_t info;
  logic        valid_q;
  status_e     status_q, status_d;
  logic [31:0] value_q, err_q, err_d;

  assign in_stall_o = valid_q && out_stall_i;
  assign beat       = in_valid_i && !in_stall_o;

  srfr_collect u_collect (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .beat_i           (beat),
    .rx_byte_i        (rx_byte_i),
    .start_byte_i     (start_q),
    .device_address_i (addr_q),
    .info_o           (info)
  );

  always_comb begin
    err_d = err_q;
    priority if (!info.addr_ok) begin
      status_d = ST_ADDRESS;
    end else if (!info.sum_ok) begin
      status_d = ST_CHECKSUM;
      err_d    = err_q + 32'd1;
    end else if (!info.cmd_ok) begin
      status_d = ST_COMMAND;
    end else if (value_invalid(info.value)) begin
      status_d = ST_VALUE;
      err_d    = err_q + 32'd1;
    end else begin
      status_d = ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= 8'd6;
      addr_q  <= 8'd1;
      valid_q <= 1'b0;
      err_q   <= 32'd0;
    end else begin
      if (cfg_we_i) begin
        unique case (reg_idx_e'(cfg_index_i))
          REG_START_BYTE: start_q <= cfg_data_i;
          REG_DEV_ADDR:   addr_q  <= cfg_data_i;
          default: ;
        endcase
      end
      if (info.done) begin
        valid_q <= 1'b1;
        err_q   <= err_d;
      end else if (!out_stall_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (info.done) begin
      status_q <= status_d;
      value_q  <= info.value;
    end
  end

  assign out_valid_o   = valid_q;
  assign status_o      = status_q;
  assign value_bits_o  = value_q;
  assign error_total_o = err_q;
endmodule

// ===== test/sensor_reply_frame_receiver_core_test.sv =====
// Testbench for sensor_reply_frame_receiver_core: drives byte beats, predicts
// frame results in a local model and checks each result beat. Uses srfr_pkg.
module sensor_reply_frame_receiver_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import srfr_pkg::*;

  typedef struct {
    status_e     status;
    logic [31:0] bits;
    logic [31:0] total;
  } frame_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  rx_byte_i = 8'd0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [2:0]  status_o;
  logic [31:0] value_bits_o;
  logic [31:0] error_total_o;
  logic        cfg_we_i = 1'b0;
  logic [0:0]  cfg_index_i = REG_START_BYTE;
  logic [7:0]  cfg_data_i = 8'd0;

  sensor_reply_frame_receiver_core uut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  logic [7:0]    byte_queue[$];
  frame_result_t result_queue[$];
  int            send_idle_pct = 0;
  int            recv_stall_pct = 0;
  bit            hold_off = 1'b0;
  int            mismatches = 0;
  int            idle_cycles = 0;
  bit            stim_done = 1'b0;

  // predictor state
  logic [7:0]  p_start = 8'd6;
  logic [7:0]  p_addr = 8'd1;
  bit          p_open = 1'b0;
  int          p_count = 0;
  logic [7:0]  p_frame[12];
  logic [31:0] p_errors = 32'd0;

  function automatic bit bits_bad(logic [31:0] b);
    logic [30:0] m;
    m = b[30:0];
    if (m >= 31'h7F80_0000) return 1'b1;
    if (!b[31] && m > 31'h453B_8000) return 1'b1;
    if (b[31] && m > 31'h42C8_0000) return 1'b1;
    return 1'b0;
  endfunction

  task automatic predict_byte(logic [7:0] b);
    frame_result_t r;
    logic [7:0] x;
    if (!p_open) begin
      if (b == p_start) begin
        p_open = 1'b1;
        p_frame[0] = b;
        p_count = 1;
      end
      return;
    end
    p_frame[p_count] = b;
    p_count++;
    if (p_count < 12) return;
    p_open = 1'b0;
    p_count = 0;
    r.bits = {p_frame[7], p_frame[8], p_frame[9], p_frame[10]};
    x = 8'd0;
    for (int i = 0; i < 11; i++) x ^= p_frame[i];
    if (p_frame[1] != p_addr) r.status = ST_ADDRESS;
    else if (x != p_frame[11]) begin
      r.status = ST_CHECKSUM;
      p_errors++;
    end else if (p_frame[2] != CmdMeasure) r.status = ST_COMMAND;
    else if (bits_bad(r.bits)) begin
      r.status = ST_VALUE;
      p_errors++;
    end else r.status = ST_OK;
    r.total = p_errors;
    result_queue.push_back(r);
  endtask

  // driver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!(in_valid_i && in_stall_o)) begin
        if (byte_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid_i <= 1'b1;
          rx_byte_i <= byte_queue.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_stall_i <= hold_off || ($urandom_range(99) < recv_stall_pct);
    end
  end

  // monitor
  always @(posedge clk_i) begin
    frame_result_t e;
    if (rst_ni) begin
      idle_cycles++;
      if (in_valid_i && !in_stall_o) begin
        idle_cycles = 0;
        predict_byte(rx_byte_i);
      end
      if (out_valid_o && !out_stall_i) begin
        idle_cycles = 0;
        if (result_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result beat status=%0d", status_o);
        end else begin
          e = result_queue.pop_front();
          if (status_o !== e.status || value_bits_o !== e.bits ||
              error_total_o !== e.total) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp %0d %h %0d got %0d %h %0d", e.status, e.bits,
                       e.total, status_o, value_bits_o, error_total_o);
          end
        end
      end
      if (idle_cycles >= 20000) begin
        $display("[sensor_reply_frame_receiver_core] ERROR");
        $finish;
      end
    end
  end

  task automatic push_frame(logic [7:0] addr, logic [7:0] cmd, logic [31:0] v,
                            bit bad_sum);
    logic [7:0] f[12];
    logic [7:0] x;
    f[0] = p_start;
    f[1] = addr;
    f[2] = cmd;
    for (int i = 3; i < 7; i++) f[i] = 8'($urandom_range(255));
    {f[7], f[8], f[9], f[10]} = v;
    x = 8'd0;
    for (int i = 0; i < 11; i++) x ^= f[i];
    f[11] = bad_sum ? x ^ (8'd1 << $urandom_range(7)) : x;
    for (int i = 0; i < 12; i++) byte_queue.push_back(f[i]);
  endtask

  // open frames left by noise are filled up so nothing stays in flight
  task automatic drain();
    do begin
      wait (byte_queue.size() == 0);
      @(posedge clk_i);
      while (in_valid_i) @(posedge clk_i);
      if (p_open) repeat (12 - p_count) byte_queue.push_back(8'($urandom()));
    end while (byte_queue.size() > 0);
    while (result_queue.size() > 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [7:0] d);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= d;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_START_BYTE) p_start = d;
    else p_addr = d;
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(7))
      0: return 32'h7F80_0000 | ($urandom_range(1) << 31) | $urandom_range(3);
      1: return 32'h453B_8000 + $urandom_range(2) - 1;
      2: return 32'hC2C8_0000 + $urandom_range(2) - 1;
      3: return $urandom();
      4: return {1'($urandom_range(1)), 31'h0};
      default: return {1'b0, 31'($urandom_range(32'h453B_8000))};
    endcase
  endfunction

  task automatic random_part(int n);
    int u;
    repeat (n) begin
      u = $urandom_range(99);
      if (u < 80) begin
        push_frame(($urandom_range(9) == 0) ? 8'($urandom()) : p_addr,
                   ($urandom_range(9) == 0) ? 8'($urandom()) : CmdMeasure,
                   pick_value(), $urandom_range(7) == 0);
      end else if (u < 90) begin
        repeat ($urandom_range(1, 4)) byte_queue.push_back(8'($urandom()));
      end else begin
        byte_queue.push_back(p_start);
        repeat ($urandom_range(1, 10)) byte_queue.push_back(8'($urandom()));
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    // directed: noise, all status codes, value limits
    byte_queue.push_back(8'h00);
    byte_queue.push_back(8'hFF);
    push_frame(p_addr, CmdMeasure, 32'h453B_8000, 0);
    push_frame(p_addr, CmdMeasure, 32'h453B_8001, 0);
    push_frame(p_addr, CmdMeasure, 32'hC2C8_0001, 0);
    push_frame(p_addr, CmdMeasure, 32'h8000_0000, 0);
    push_frame(p_addr, CmdMeasure, 32'hFFFF_FFFF, 0);
    push_frame(p_addr, 8'h02, 32'h7F80_0000, 0);
    push_frame(8'hFF, CmdMeasure, 32'h0, 1);
    push_frame(p_addr, CmdMeasure, 32'h0, 1);
    drain();
    write_reg(REG_START_BYTE, 8'hFF);
    write_reg(REG_DEV_ADDR, 8'h00);
    push_frame(p_addr, CmdMeasure, 32'h3F80_0000, 0);
    push_frame(p_addr, CmdMeasure, 32'h0000_0001, 0);
    random_part(30);
    drain();
    write_reg(REG_START_BYTE, 8'h00);
    write_reg(REG_DEV_ADDR, 8'hFF);
    send_idle_pct = 45;
    random_part(40);
    drain();
    write_reg(REG_START_BYTE, 8'h06);
    write_reg(REG_DEV_ADDR, 8'h01);
    send_idle_pct = 0;
    recv_stall_pct = 45;
    random_part(40);
    drain();
    write_reg(REG_START_BYTE, 8'($urandom()));
    write_reg(REG_DEV_ADDR, 8'($urandom()));
    send_idle_pct = 31;
    recv_stall_pct = 31;
    random_part(40);
    drain();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    random_part(10);
    stim_done = 1'b1;
    drain();
    if (mismatches == 0) $display("[sensor_reply_frame_receiver_core] OK");
    else $display("[sensor_reply_frame_receiver_core] ERROR");
    $finish;
  end

  // long receiver hold-off while bytes are still offered; input stalls once a result is held
  initial begin
    wait (stim_done);
    @(negedge clk_i);
    hold_off = 1'b1;
    repeat (300) @(negedge clk_i);
    hold_off = 1'b0;
  end
endmodule
